// File: rtl/mpwm_pkg.sv
// Shared constants, types and helpers for the multichannel PWM generator.
`default_nettype none

package mpwm_pkg;

  // Channel and field sizes
  localparam int CHANNELS = 8;
  localparam int PIN_W    = 8;
  localparam int CH_IDX_W = 3;
  localparam int COUNT_W  = 4;
  localparam int NS_W     = 32;
  localparam int TICK_W   = 23;

  // Reset values: 20 ms period, 1 ms high time, in 1 us ticks
  localparam logic [COUNT_W-1:0] COUNT_RESET    = 4'd8;
  localparam logic [TICK_W-1:0]  RESET_HI_TICKS = 23'd1000;
  localparam logic [TICK_W-1:0]  RESET_LO_TICKS = 23'd19000;

  // x / 1000 == (x * ceil(2^38 / 1000)) >> 38, exact for any 32-bit x
  localparam int                 RECIP_W     = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000  = 29'd274877907;
  localparam int                 RECIP_SHIFT = 38;
  localparam int                 PROD_W      = NS_W + RECIP_W;

  // Item kinds
  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // Result status codes
  localparam logic ST_OK    = 1'b0;
  localparam logic ST_RANGE = 1'b1;

  // Phase state loaded at a period start
  typedef struct packed {
    logic              high;
    logic [TICK_W-1:0] ticks;
    logic [TICK_W-1:0] latched;
  } phase_t;

  // Per-channel command from the item pipeline
  typedef struct packed {
    logic              tick;
    logic              wr;
    logic              enable;
    logic [TICK_W-1:0] hi_ticks;
    logic [TICK_W-1:0] lo_ticks;
  } chan_cmd_t;

  // Phase state at the start of a period; empty periods give one low tick
  function automatic phase_t start_period(input logic [TICK_W-1:0] hi,
                                          input logic [TICK_W-1:0] lo);
    phase_t ph;
    if (hi != '0) begin
      ph.high    = 1'b1;
      ph.ticks   = hi;
      ph.latched = lo;
    end else if (lo != '0) begin
      ph.high    = 1'b0;
      ph.ticks   = lo;
      ph.latched = '0;
    end else begin
      ph.high    = 1'b0;
      ph.ticks   = TICK_W'(1);
      ph.latched = '0;
    end
    return ph;
  endfunction

endpackage

`default_nettype wire

// File: rtl/multichannel_pwm_generator.sv
// Top level of the multichannel PWM generator.
// Pipeline: input register, clamp stage, divide-by-1000 multiply stage, then channel
//   update with result register.
// Throughput: one item per cycle; the four-stage pipeline stalls only on output backpressure.
// Reset: synchronous; clears the pipeline, disables all channels, sets pending
//   settings to 20 ms / 1 ms and the channel count to 8.
`default_nettype none

module multichannel_pwm_generator (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration write
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mpwm_pkg::COUNT_W-1:0]  cfg_data,
  // input items
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          action,
  input  wire logic [mpwm_pkg::CH_IDX_W-1:0] channel_index,
  input  wire logic [mpwm_pkg::NS_W-1:0]     period_value,
  input  wire logic [mpwm_pkg::NS_W-1:0]     duty_value,
  input  wire logic                          enable_flag,
  // result items
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [mpwm_pkg::PIN_W-1:0]    pin_levels,
  output logic                               status
);
  import mpwm_pkg::*;

  logic [COUNT_W-1:0]  channel_count;
  logic [COUNT_W-1:0]  limit;
  logic                reject;
  logic                in_acc;
  logic                v0, v1, v2;
  logic                go0, go1, go2, go3;
  logic                space1, space2, space3;
  logic                act0, act1, act2;
  logic [CH_IDX_W-1:0] idx0, idx1, idx2;
  logic                en0, en1, en2;
  logic [NS_W-1:0]     per0, duty0;
  logic [TICK_W-1:0]   hi_ticks, lo_ticks;
  logic [CHANNELS-1:0] level;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= COUNT_RESET;
    end else if (cfg_valid) begin
      channel_count <= cfg_data;
    end
  end

  // Pipeline flow control
  assign go3    = out_valid && out_ready;
  assign space3 = !out_valid || out_ready;
  assign go2    = v2 && space3;
  assign space2 = !v2 || go2;
  assign go1    = v1 && space2;
  assign space1 = !v1 || go1;
  assign go0    = v0 && space1;
  assign in_ready = !v0 || go0;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v0        <= in_acc || (v0 && !go0);
      v1        <= go0 || (v1 && !go1);
      v2        <= go1 || (v2 && !go2);
      out_valid <= go2 || (out_valid && !go3);
    end
  end

  // Item payload through the stages
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act0  <= action;
      idx0  <= channel_index;
      en0   <= enable_flag;
      per0  <= period_value;
      duty0 <= duty_value;
    end
    if (go0) begin
      act1 <= act0;
      idx1 <= idx0;
      en1  <= en0;
    end
    if (go1) begin
      act2 <= act1;
      idx2 <= idx1;
      en2  <= en1;
    end
  end

  mpwm_conv u_conv (
    .clk        (clk),
    .ld_clamp   (go0),
    .ld_scale   (go1),
    .period_len (per0),
    .duty_ns    (duty0),
    .hi_ticks   (hi_ticks),
    .lo_ticks   (lo_ticks)
  );

  // Range check against the configured channel count
  assign limit  = (channel_count > COUNT_W'(CHANNELS)) ? COUNT_W'(CHANNELS) : channel_count;
  assign reject = (act2 == ACT_WRITE) && ({1'b0, idx2} >= limit);

  always_ff @(posedge clk) begin
    if (go2) begin
      status <= reject ? ST_RANGE : ST_OK;
    end
  end

  // Channels update as an item enters the result register
  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    chan_cmd_t cmd;

    assign cmd.tick     = go2 && (act2 == ACT_TICK);
    assign cmd.wr       = go2 && (act2 == ACT_WRITE) && !reject &&
                          (idx2 == CH_IDX_W'(c));
    assign cmd.enable   = en2;
    assign cmd.hi_ticks = hi_ticks;
    assign cmd.lo_ticks = lo_ticks;

    mpwm_chan u_chan (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .level (level[c])
    );
  end

  // Channel state only changes when a new result is loaded, so pins track it
  always_comb begin
    pin_levels = '0;
    for (int i = 0; i < PIN_W; i++) begin
      if (i < CHANNELS) begin
        pin_levels[i] = level[i];
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/mpwm_conv.sv
// Two-stage conversion of period and duty in ns to high and low tick counts.
`default_nettype none

module mpwm_conv (
  input  wire logic                        clk,
  input  wire logic                        ld_clamp,
  input  wire logic                        ld_scale,
  input  wire logic [mpwm_pkg::NS_W-1:0]   period_len,
  input  wire logic [mpwm_pkg::NS_W-1:0]   duty_ns,
  output logic      [mpwm_pkg::TICK_W-1:0] hi_ticks,
  output logic      [mpwm_pkg::TICK_W-1:0] lo_ticks
);
  import mpwm_pkg::*;

  logic [NS_W-1:0]   duty_clamped;
  logic [NS_W-1:0]   high_ns;
  logic [NS_W-1:0]   low_ns;
  logic [PROD_W-1:0] hi_prod;
  logic [PROD_W-1:0] lo_prod;

  // Stage 1: clamp duty to period, split into high and low ns
  assign duty_clamped = (duty_ns > period_len) ? period_len : duty_ns;

  always_ff @(posedge clk) begin
    if (ld_clamp) begin
      high_ns <= duty_clamped;
      low_ns  <= period_len - duty_clamped;
    end
  end

  // Stage 2: divide by 1000 through a reciprocal multiply
  assign hi_prod = PROD_W'(high_ns) * PROD_W'(RECIP_1000);
  assign lo_prod = PROD_W'(low_ns) * PROD_W'(RECIP_1000);

  always_ff @(posedge clk) begin
    if (ld_scale) begin
      hi_ticks <= hi_prod[RECIP_SHIFT +: TICK_W];
      lo_ticks <= lo_prod[RECIP_SHIFT +: TICK_W];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mpwm_chan.sv
// One PWM channel: pending settings, phase counter and pin level.
`default_nettype none

module mpwm_chan (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mpwm_pkg::chan_cmd_t cmd,
  output logic                     level
);
  import mpwm_pkg::*;

  logic              enabled, enabled_next;
  logic              high, high_next;
  logic [TICK_W-1:0] ticks_left, ticks_left_next;
  logic [TICK_W-1:0] latched_low, latched_low_next;
  logic [TICK_W-1:0] pend_hi, pend_hi_next;
  logic [TICK_W-1:0] pend_lo, pend_lo_next;
  logic [TICK_W-1:0] dec;
  phase_t            pend_ph;
  phase_t            new_ph;

  assign pend_ph = start_period(pend_hi, pend_lo);
  assign new_ph  = start_period(cmd.hi_ticks, cmd.lo_ticks);
  assign dec     = (ticks_left != '0) ? ticks_left - TICK_W'(1) : ticks_left;

  // Next state for a tick or a write to this channel
  always_comb begin
    enabled_next     = enabled;
    high_next        = high;
    ticks_left_next  = ticks_left;
    latched_low_next = latched_low;
    pend_hi_next     = pend_hi;
    pend_lo_next     = pend_lo;
    if (cmd.tick && enabled) begin
      if (dec != '0) begin
        ticks_left_next = dec;
      end else if (high && latched_low != '0) begin
        // high phase over, low phase follows
        high_next        = 1'b0;
        ticks_left_next  = latched_low;
        latched_low_next = '0;
      end else begin
        high_next        = pend_ph.high;
        ticks_left_next  = pend_ph.ticks;
        latched_low_next = pend_ph.latched;
      end
    end else if (cmd.wr) begin
      pend_hi_next = cmd.hi_ticks;
      pend_lo_next = cmd.lo_ticks;
      if (cmd.enable) begin
        // an idle channel starts a period at once from the new values
        if (!enabled) begin
          enabled_next     = 1'b1;
          high_next        = new_ph.high;
          ticks_left_next  = new_ph.ticks;
          latched_low_next = new_ph.latched;
        end
      end else begin
        enabled_next     = 1'b0;
        high_next        = 1'b0;
        ticks_left_next  = '0;
        latched_low_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled     <= 1'b0;
      high        <= 1'b0;
      ticks_left  <= '0;
      latched_low <= '0;
      pend_hi     <= RESET_HI_TICKS;
      pend_lo     <= RESET_LO_TICKS;
    end else begin
      enabled     <= enabled_next;
      high        <= high_next;
      ticks_left  <= ticks_left_next;
      latched_low <= latched_low_next;
      pend_hi     <= pend_hi_next;
      pend_lo     <= pend_lo_next;
    end
  end

  assign level = enabled && high;

endmodule

`default_nettype wire

// File: rtl/mpwm_checker.sv
// Port-level checks for the multichannel PWM generator, bound to the top level.
`default_nettype none

module mpwm_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic [mpwm_pkg::PIN_W-1:0] pin_levels,
  input wire logic                       status
);
  import mpwm_pkg::*;

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pin_levels) && $stable(status))
    else $error("stalled result changed");

  // Pins only move when a result item is presented
  a_pins_with_item: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$stable(pin_levels) |-> out_valid)
    else $error("pins changed without a result item");

  // A rejected write leaves the pins as they were
  a_reject_no_change: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && ($past(!out_valid) || $past(out_valid && out_ready)) &&
    out_valid && (status == ST_RANGE) |-> $stable(pin_levels))
    else $error("rejected write changed the pins");

endmodule

bind multichannel_pwm_generator mpwm_checker u_mpwm_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .pin_levels (pin_levels),
  .status     (status)
);

`default_nettype wire
